/* rtl/ptc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  // Field widths of one agent record
  localparam int unsigned PosW = 20;
  localparam int unsigned VelW = 18;
  localparam int unsigned LenW = 14;
  localparam int unsigned SpdW = 16;
  localparam int unsigned AngW = 16;
  localparam int unsigned TtcW = 18;
  localparam int unsigned CntW = 32;

  // Shared multiplier and iterative unit widths
  localparam int unsigned MulW = 22;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned UnitW = 42;
  localparam int unsigned StepW = 6;

  localparam logic [TtcW-1:0] TtcNone = 18'd255744;
  localparam logic [StepW-1:0] DivSteps = 6'd42;
  localparam logic [StepW-1:0] SqrtSteps = 6'd16;

  // Configuration register indexes
  localparam logic [1:0] RegCriticalTtc = 2'd0;
  localparam logic [1:0] RegMaxPairDist = 2'd1;
  localparam logic [1:0] RegMinClosing = 2'd2;

  // Q14 quarter-wave sine points, 1024 angle steps apart
  localparam logic [14:0] QuarterTab [17] = '{
    15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102, 15'd10394,
    15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137, 15'd15679, 15'd16069,
    15'd16305, 15'd16384
  };

  typedef enum logic [0:0] {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } ptc_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_VINT, ST_VSCL, ST_VRND, ST_WRITE,
    ST_PINIT, ST_PLIM, ST_RDI, ST_RDJ, ST_LATJ,
    ST_DX2, ST_DY2, ST_DCHK, ST_SQRT, ST_PX, ST_PY, ST_PCHK,
    ST_DIV1, ST_DIV2, ST_NEXT, ST_OUT
  } ptc_state_e;

  typedef struct packed {
    logic                   start;
    ptc_op_e                op;
    logic [UnitW-1:0]       a;
    logic [UnitW-1:0]       b;
  } ptc_unit_req_t;

  typedef struct packed {
    logic                   done;
    logic [UnitW-1:0]       result;
  } ptc_unit_rsp_t;

  typedef struct packed {
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic [LenW-1:0]        len;
  } ptc_agent_t;

  typedef struct packed {
    logic                   full;
    logic                   neg;
    logic [14:0]            base;
    logic [10:0]            diff;
    logic [9:0]             frac;
  } ptc_sine_t;

  // Split a binary angle into table point, slope and fraction
  function automatic ptc_sine_t ptc_sine(input logic [AngW-1:0] h);
    logic [14:0] qq;
    logic [4:0]  idx;
    ptc_sine_t   r;
    qq = h[14] ? (15'd16384 - {1'b0, h[13:0]}) : {1'b0, h[13:0]};
    idx = {1'b0, qq[13:10]};
    r.full = qq[14];
    r.neg = h[15];
    r.base = QuarterTab[idx];
    r.diff = 11'(QuarterTab[idx + 5'd1] - QuarterTab[idx]);
    r.frac = qq[9:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ptc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/ptc_iter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptc_iter_unit
  import ptc_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ptc_unit_req_t req_i,
  output ptc_unit_rsp_t      rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  ptc_op_e          op_q, op_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [UnitW:0]   rem_q, rem_d;
  logic [UnitW-1:0] quo_q, quo_d;
  logic [UnitW-1:0] src_q, src_d;
  logic [UnitW-1:0] div_q, div_d;
  logic [UnitW:0]   cand, trial, diff;
  logic             ge;

  // Pick partial remainder and trial value for one restoring step
  always_comb begin
    if (op_q == OP_SQRT) begin
      cand = {rem_q[UnitW-2:0], src_q[UnitW-1:UnitW-2]};
      trial = {quo_q[UnitW-2:0], 2'b01};
    end else begin
      cand = {rem_q[UnitW-1:0], src_q[UnitW-1]};
      trial = {1'b0, div_q};
    end
    ge = (cand >= trial);
    diff = cand - trial;
  end

  // Load on request, then one quotient or root bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d = op_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    src_d = src_q;
    div_d = div_q;
    if (busy_q) begin
      rem_d = ge ? diff : cand;
      quo_d = {quo_q[UnitW-2:0], ge};
      src_d = (op_q == OP_SQRT) ? {src_q[UnitW-3:0], 2'b00} : {src_q[UnitW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      op_d = req_i.op;
      rem_d = '0;
      quo_d = '0;
      div_d = req_i.b;
      if (req_i.op == OP_SQRT) begin
        src_d = {req_i.a[31:0], 10'd0};
        cnt_d = SqrtSteps;
      end else begin
        src_d = req_i.a;
        cnt_d = DivSteps;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q <= OP_DIV;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q <= op_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    src_q <= src_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.result = quo_q;

endmodule

`default_nettype wire

/* rtl/pairwise_time_to_collision_screen_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pairwise time-to-collision screen.
// Input stream: one agent record per request. tdata carries position, speed,
// heading and body length; tuser marks a present agent; tlast closes the set.
// Each present record is loaded into an agent table while it has room
// (velocity formed from a sine table by the shared multiplier). The
// request with tlast starts a pass over all unordered pairs of loaded
// agents, then one result leaves on the output stream: the minimum TTC
// (255744 if none) and the running violation count. A pair runs through
// one shared multiplier and one iterative divide/root unit: a pair screened
// out by distance ends there; any other pair takes 16 root steps, then, if
// closing, one 42-step division for its closing speed and, if that is fast
// enough, a second one for its TTC. A set of N agents needs N*(N-1)/2 such
// pair slots plus setup and output.
// The input is not ready while an item is worked on. A finished result sits
// in the output register and the block then returns to taking requests; a
// new result, and the block with it, waits until the receiver has taken the old one.
// Reset empties the table, clears the violation count and loads the default
// registers; no clearing pass is needed.
module pairwise_time_to_collision_screen_unit
  import ptc_pkg::*;
#(
  parameter int unsigned MAX_AGENTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [17:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x[19:0], pos_y[39:20], speed[55:40], heading[71:56], body_length[85:72]
  input  wire logic [87:0] s_axis_tdata,
  // present[0]
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // min_ttc[17:0], violation_total[49:18]
  output logic [55:0]      m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(MAX_AGENTS);
  localparam int unsigned NumW = $clog2(MAX_AGENTS + 1);
  localparam logic [NumW-1:0] MaxNum = NumW'(MAX_AGENTS);

  ptc_state_e state_q, state_d;

  // Configuration registers
  logic [TtcW-1:0] crit_q;
  logic [15:0]     mpd_q, minc_q;

  // Input record hold
  logic                   present_q, last_q;
  logic signed [PosW-1:0] inx_q, iny_q;
  logic [SpdW-1:0]        speed_q;
  logic [AngW-1:0]        head_q;
  logic [LenW-1:0]        len_q;
  logic                   sel_q;
  logic signed [VelW-1:0] velx_q, vely_q;

  // Pass state
  logic [NumW-1:0]        count_q;
  logic [IdxW-1:0]        i_q, j_q;
  logic [TtcW-1:0]        rmin_q;
  logic [CntW-1:0]        viol_q;
  logic [31:0]            lim_q;
  logic [15:0]            dist_q;
  ptc_agent_t             ent_a_q, ent_b_q;

  // Shared multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_q, acc_q;

  // Table and iterative unit
  logic                    ram_we;
  logic [IdxW-1:0]         ram_raddr;
  ptc_agent_t              ram_wdata, ram_rdata;
  ptc_unit_req_t           unit_req;
  ptc_unit_rsp_t           unit_rsp;

  logic                    m_valid_q;
  logic [55:0]             m_data_q;

  // Derived datapath values
  logic [AngW-1:0]         angle;
  ptc_sine_t               sn;
  logic [14:0]             sine_mag;
  logic [ProdW-1:0]        rnd;
  logic [16:0]             vmag;
  logic signed [VelW-1:0]  vel;
  logic signed [20:0]      dx, dy;
  logic signed [18:0]      rvx, rvy;
  logic signed [ProdW-1:0] sum2;
  logic [16:0]             two_dist;
  logic [14:0]             lens;
  logic [16:0]             gap2;
  logic [NumW-1:0]         j_next;
  logic [NumW:0]           i_plus2;
  logic                    row_end, pass_end, can_load;
  logic [UnitW-1:0]        ttc;

  ptc_ram #(
    .WIDTH ($bits(ptc_agent_t)),
    .DEPTH (MAX_AGENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptc_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  // Velocity arithmetic
  always_comb begin
    angle = sel_q ? head_q : head_q + 16'd16384;
    sn = ptc_sine(angle);
    sine_mag = sn.full ? 15'd16384 : sn.base + 15'(prod_q[20:10]);
    rnd = prod_q + 44'sd8192;
    vmag = rnd[30:14];
    vel = sn.neg ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
  end

  // Pair arithmetic
  always_comb begin
    dx = $signed({ent_b_q.px[PosW-1], ent_b_q.px}) - $signed({ent_a_q.px[PosW-1], ent_a_q.px});
    dy = $signed({ent_b_q.py[PosW-1], ent_b_q.py}) - $signed({ent_a_q.py[PosW-1], ent_a_q.py});
    rvx = $signed({ent_b_q.vx[VelW-1], ent_b_q.vx}) - $signed({ent_a_q.vx[VelW-1], ent_a_q.vx});
    rvy = $signed({ent_b_q.vy[VelW-1], ent_b_q.vy}) - $signed({ent_a_q.vy[VelW-1], ent_a_q.vy});
    sum2 = acc_q + prod_q;
    two_dist = {dist_q, 1'b0};
    lens = {1'b0, ent_a_q.len} + {1'b0, ent_b_q.len};
    gap2 = (two_dist > {2'b00, lens}) ? two_dist - {2'b00, lens} : 17'd0;
    ttc = unit_rsp.result;
    j_next = {{(NumW - IdxW){1'b0}}, j_q} + 1'b1;
    i_plus2 = {{(NumW + 1 - IdxW){1'b0}}, i_q} + 2'd2;
    row_end = (j_next == count_q);
    pass_end = (i_plus2 >= {1'b0, count_q});
    can_load = present_q && (count_q < MaxNum);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_CHK;
      ST_CHK: begin
        if (can_load) state_d = ST_VINT;
        else if (last_q) state_d = ST_PINIT;
        else state_d = ST_IDLE;
      end
      ST_VINT:  state_d = ST_VSCL;
      ST_VSCL:  state_d = ST_VRND;
      ST_VRND:  state_d = sel_q ? ST_WRITE : ST_VINT;
      ST_WRITE: state_d = last_q ? ST_PINIT : ST_IDLE;
      ST_PINIT: state_d = ST_PLIM;
      ST_PLIM:  state_d = (count_q < 2) ? ST_OUT : ST_RDI;
      ST_RDI:   state_d = ST_RDJ;
      ST_RDJ:   state_d = ST_LATJ;
      ST_LATJ:  state_d = ST_DX2;
      ST_DX2:   state_d = ST_DY2;
      ST_DY2:   state_d = ST_DCHK;
      ST_DCHK: begin
        if (sum2 == 0 || sum2 > $signed({12'd0, lim_q})) state_d = ST_NEXT;
        else state_d = ST_SQRT;
      end
      ST_SQRT:  if (unit_rsp.done) state_d = ST_PX;
      ST_PX:    state_d = ST_PY;
      ST_PY:    state_d = ST_PCHK;
      ST_PCHK:  state_d = (sum2 < 0) ? ST_DIV1 : ST_NEXT;
      ST_DIV1: begin
        if (unit_rsp.done) begin
          state_d = (unit_rsp.result > {26'd0, minc_q}) ? ST_DIV2 : ST_NEXT;
        end
      end
      ST_DIV2:  if (unit_rsp.done) state_d = ST_NEXT;
      ST_NEXT:  state_d = (row_end && pass_end) ? ST_OUT : ST_RDI;
      ST_OUT:   if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs: multiplier operands, table port, unit requests
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    ram_we = 1'b0;
    ram_raddr = i_q;
    ram_wdata = '{px: inx_q, py: iny_q, vx: velx_q, vy: vely_q, len: len_q};
    unit_req = '{start: 1'b0, op: OP_DIV, a: '0, b: '0};
    case (state_q)
      ST_VINT: begin
        mul_a = MulW'({1'b0, sn.diff});
        mul_b = MulW'({1'b0, sn.frac});
      end
      ST_VSCL: begin
        mul_a = MulW'({1'b0, speed_q});
        mul_b = MulW'({1'b0, sine_mag});
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      ST_PINIT: begin
        mul_a = MulW'({1'b0, mpd_q});
        mul_b = MulW'({1'b0, mpd_q});
      end
      ST_RDJ:   ram_raddr = j_q;
      ST_DX2: begin
        mul_a = MulW'(dx);
        mul_b = MulW'(dx);
      end
      ST_DY2: begin
        mul_a = MulW'(dy);
        mul_b = MulW'(dy);
      end
      ST_DCHK: begin
        unit_req.start = !(sum2 == 0 || sum2 > $signed({12'd0, lim_q}));
        unit_req.op = OP_SQRT;
        unit_req.a = sum2[UnitW-1:0];
      end
      ST_PX: begin
        mul_a = MulW'(dx);
        mul_b = MulW'(rvx);
      end
      ST_PY: begin
        mul_a = MulW'(dy);
        mul_b = MulW'(rvy);
      end
      ST_PCHK: begin
        unit_req.start = (sum2 < 0);
        unit_req.a = 42'(-sum2);
        unit_req.b = {26'd0, dist_q};
      end
      ST_DIV1: begin
        unit_req.start = unit_rsp.done && (unit_rsp.result > {26'd0, minc_q});
        unit_req.a = {18'd0, gap2, 7'd0};
        unit_req.b = unit_rsp.result;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      crit_q <= 18'd384;
      mpd_q <= 16'd2240;
      minc_q <= 16'd16;
      count_q <= '0;
      rmin_q <= TtcNone;
      viol_q <= '0;
      m_valid_q <= 1'b0;
      sel_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
    end else begin
      state_q <= state_d;
      // Take configuration writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegCriticalTtc: crit_q <= cfg_wdata_i;
          RegMaxPairDist: mpd_q <= cfg_wdata_i[15:0];
          RegMinClosing:  minc_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      // Raise a new result, drop the old one once taken
      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CHK:   sel_q <= 1'b0;
        ST_VRND:  sel_q <= 1'b1;
        ST_WRITE: count_q <= count_q + 1'b1;
        ST_PINIT: begin
          rmin_q <= TtcNone;
          i_q <= '0;
          j_q <= IdxW'(1);
        end
        ST_DIV2: begin
          if (unit_rsp.done) begin
            if (ttc < {24'd0, rmin_q}) rmin_q <= ttc[TtcW-1:0];
            if (ttc < {24'd0, crit_q} && viol_q != '1) viol_q <= viol_q + 1'b1;
          end
        end
        ST_NEXT: begin
          if (row_end) begin
            i_q <= i_q + 1'b1;
            j_q <= i_plus2[IdxW-1:0];
          end else begin
            j_q <= j_next[IdxW-1:0];
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            count_q <= '0;
            rmin_q <= TtcNone;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      present_q <= s_axis_tuser[0];
      last_q <= s_axis_tlast;
      inx_q <= s_axis_tdata[19:0];
      iny_q <= s_axis_tdata[39:20];
      speed_q <= s_axis_tdata[55:40];
      head_q <= s_axis_tdata[71:56];
      len_q <= s_axis_tdata[85:72];
    end
    if (state_q == ST_VRND) begin
      if (sel_q) vely_q <= vel;
      else velx_q <= vel;
    end
    if (state_q == ST_PLIM) lim_q <= prod_q[31:0];
    if (state_q == ST_RDJ) ent_a_q <= ram_rdata;
    if (state_q == ST_LATJ) ent_b_q <= ram_rdata;
    if (state_q == ST_DY2 || state_q == ST_PY) acc_q <= prod_q;
    if (state_q == ST_SQRT && unit_rsp.done) dist_q <= unit_rsp.result[15:0];
    if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {6'd0, viol_q, rmin_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;

endmodule

`default_nettype wire

/* rtl/ptc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Work on one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request");

  // Minimum TTC never exceeds the no-pair value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:0] <= 18'd255744)
    else $error("min_ttc above saturation");

  // A request without tlast produces no new result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result without closing request");

endmodule

bind pairwise_time_to_collision_screen_unit ptc_checker u_ptc_checker (.*);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned SlotCnt = 64;
  localparam int unsigned StallLimit = 700000;

  typedef struct {
    bit        present;
    int        px;
    int        py;
    int        speed;
    int        heading;
    int        len;
    bit        last;
  } agent_rec_t;

  typedef struct {
    logic [TtcW-1:0] min_ttc;
    logic [CntW-1:0] total;
  } screen_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [17:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  pairwise_time_to_collision_screen_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Screen state mirrored on the testbench side
  int unsigned crit_ttc = 384;
  int unsigned max_dist = 2240;
  int unsigned min_close = 16;
  longint ag_px [SlotCnt];
  longint ag_py [SlotCnt];
  longint ag_vx [SlotCnt];
  longint ag_vy [SlotCnt];
  longint ag_len [SlotCnt];
  int unsigned agent_cnt = 0;
  longint unsigned viol_cnt = 0;

  agent_rec_t  record_q [$];
  screen_res_t screen_expect_q [$];
  int unsigned errors = 0;
  bit          idle_on = 1'b1;

  function automatic int quarter_wave(input int q);
    int tab [17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                     12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
    int i;
    int f;
    if (q >= 16384) return 16384;
    i = q >> 10;
    f = q & 1023;
    return tab[i] + (((tab[i+1] - tab[i]) * f) >> 10);
  endfunction

  function automatic int sine_q14(input int h);
    int quad;
    int q;
    int m;
    h = h & 65535;
    quad = h >> 14;
    q = h & 16383;
    m = quad[0] ? quarter_wave(16384 - q) : quarter_wave(q);
    return (quad >= 2) ? -m : m;
  endfunction

  function automatic longint scale_speed(input int speed, input int s);
    longint mag;
    longint r;
    mag = (s < 0) ? -s : s;
    r = (longint'(speed) * mag + 8192) >>> 14;
    return (s < 0) ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned d);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > d) b = b >> 2;
    while (b != 0) begin
      if (d >= res + b) begin
        d = d - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Screen every unordered pair and return the smallest TTC
  function automatic longint screen_pairs();
    longint best;
    longint dx, dy, d2, lim, pair_dist, rvx, rvy, p, closing, lens, gap2, ttc;
    best = TtcNone;
    lim = longint'(max_dist) * longint'(max_dist);
    for (int i = 0; i < agent_cnt; i++) begin
      for (int j = i + 1; j < agent_cnt; j++) begin
        dx = ag_px[j] - ag_px[i];
        dy = ag_py[j] - ag_py[i];
        d2 = dx * dx + dy * dy;
        if (d2 == 0 || d2 > lim) continue;
        pair_dist = longint'(int_sqrt(d2));
        rvx = ag_vx[j] - ag_vx[i];
        rvy = ag_vy[j] - ag_vy[i];
        p = -(dx * rvx + dy * rvy);
        if (p <= 0) continue;
        closing = p / pair_dist;
        if (closing <= min_close) continue;
        lens = ag_len[i] + ag_len[j];
        gap2 = (2 * pair_dist > lens) ? 2 * pair_dist - lens : 0;
        ttc = (gap2 * 128) / closing;
        if (ttc < best) best = ttc;
        if (ttc < crit_ttc && viol_cnt != 64'hFFFF_FFFF) viol_cnt++;
      end
    end
    return best;
  endfunction

  // Load one accepted record and queue the result a closing record causes
  function automatic void take_record(input agent_rec_t r);
    screen_res_t res;
    if (r.present && agent_cnt < SlotCnt) begin
      ag_px[agent_cnt] = r.px;
      ag_py[agent_cnt] = r.py;
      ag_vx[agent_cnt] = scale_speed(r.speed, sine_q14(r.heading + 16384));
      ag_vy[agent_cnt] = scale_speed(r.speed, sine_q14(r.heading));
      ag_len[agent_cnt] = r.len;
      agent_cnt++;
    end
    if (r.last) begin
      res.min_ttc = TtcW'(screen_pairs());
      res.total = CntW'(viol_cnt);
      screen_expect_q = {screen_expect_q, res};
      agent_cnt = 0;
    end
  endfunction

  // Append one record to the pending requests
  function automatic void queue_rec(input agent_rec_t r);
    record_q = {record_q, r};
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Request driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    agent_rec_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) take_record(cur);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (record_q.size() > 0) begin
        cur = record_q.pop_front();
        s_axis_tdata <= {2'b0, cur.len[13:0], cur.heading[15:0], cur.speed[15:0],
                         cur.py[19:0], cur.px[19:0]};
        s_axis_tuser <= cur.present;
        s_axis_tlast <= cur.last;
        s_axis_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  int recv_gap = 0;
  always @(posedge clk_i) begin
    screen_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (screen_expect_q.size() == 0) begin
        $error("unexpected result min_ttc=%0d", m_axis_tdata[17:0]);
        errors++;
      end else begin
        exp_r = screen_expect_q.pop_front();
        if (m_axis_tdata[17:0] !== exp_r.min_ttc) begin
          $error("min_ttc expected %0d actual %0d", exp_r.min_ttc, m_axis_tdata[17:0]);
          errors++;
        end
        if (m_axis_tdata[49:18] !== exp_r.total) begin
          $error("violation_total expected %0d actual %0d", exp_r.total,
                 m_axis_tdata[49:18]);
          errors++;
        end
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
    end
  end

  // Stall watchdog
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic agent_rec_t mk(input bit pr, input int x, input int y, input int sp,
                                    input int hd, input int ln, input bit lst);
    agent_rec_t r;
    r.present = pr;
    r.px = x;
    r.py = y;
    r.speed = sp;
    r.heading = hd;
    r.len = ln;
    r.last = lst;
    return r;
  endfunction

  function automatic int clamp20(input int v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // Queue one agent set: clustered records, or full-range noise
  task automatic add_set(input int n, input int spread, input bit noise);
    int cx, cy;
    agent_rec_t r;
    cx = $urandom_range(0, 1040000) - 520000;
    cy = $urandom_range(0, 1040000) - 520000;
    for (int k = 0; k < n; k++) begin
      if (noise) begin
        r = mk($urandom_range(0, 1), $urandom_range(0, 1048575) - 524288,
               $urandom_range(0, 1048575) - 524288, $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 16383), k == n - 1);
      end else begin
        r = mk($urandom_range(0, 9) != 0,
               clamp20(cx + $urandom_range(0, 2 * spread) - spread),
               clamp20(cy + $urandom_range(0, 2 * spread) - spread),
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                         : $urandom_range(0, 4000),
               $urandom_range(0, 65535),
               $urandom_range(0, 7) == 0 ? $urandom_range(0, 16383)
                                         : $urandom_range(0, 400),
               k == n - 1);
      end
      queue_rec(r);
    end
  endtask

  task automatic add_random(input int budget);
    int n;
    int pick;
    while (budget > 0) begin
      n = $urandom_range(1, 8);
      pick = $urandom_range(0, 9);
      if (pick == 0) add_set(n, 0, 1'b1);
      else if (pick < 4) add_set(n, 64, 1'b0);
      else if (pick < 9) add_set(n, 1500, 1'b0);
      else add_set(n, 30000, 1'b0);
      budget -= n;
    end
  endtask

  // Hold until the block has drained, then let it settle
  task automatic wait_drained();
    while (record_q.size() > 0 || s_axis_tvalid || screen_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int unsigned ct, input int unsigned md,
                           input int unsigned mc);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= RegCriticalTtc;
    cfg_wdata_i <= 18'(ct);
    @(posedge clk_i);
    cfg_addr_i <= RegMaxPairDist;
    cfg_wdata_i <= 18'(md);
    @(posedge clk_i);
    cfg_addr_i <= RegMinClosing;
    cfg_wdata_i <= 18'(mc);
    @(posedge clk_i);
    cfg_addr_i <= RegUnused;
    cfg_wdata_i <= 18'($urandom_range(0, 262143));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    crit_ttc = ct;
    max_dist = md;
    min_close = mc;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Head-on pair, coincident pair, zero speed, absent and empty sets
    queue_rec(mk(1, 0, 0, 2000, 0, 100, 0));
    queue_rec(mk(1, 1600, 0, 2000, 32768, 100, 0));
    queue_rec(mk(1, 1600, 0, 500, 16384, 0, 0));
    queue_rec(mk(1, 800, 800, 0, 0, 16383, 0));
    queue_rec(mk(1, 800, 900, 65535, 49152, 50, 1));
    queue_rec(mk(1, 10, 10, 3000, 65535, 20, 0));
    queue_rec(mk(0, 12, 12, 3000, 0, 20, 1));
    queue_rec(mk(0, 0, 0, 0, 0, 0, 1));
    queue_rec(mk(1, 5, 5, 100, 100, 100, 1));
    wait_drained();

    // Widest reach, highest time threshold, any closing speed
    write_cfg(262143, 65535, 0);
    queue_rec(mk(1, -524288, -524288, 65535, 8192, 16383, 0));
    queue_rec(mk(1, -500000, -500000, 65535, 40960, 16383, 0));
    queue_rec(mk(1, 524287, 524287, 65535, 40960, 0, 0));
    queue_rec(mk(1, 524287, 480000, 65535, 16384, 0, 1));
    queue_rec(mk(1, 0, 0, 0, 0, 0, 0));
    queue_rec(mk(1, 0, 3, 7, 49152, 1, 1));
    wait_drained();

    // Nothing qualifies: no reach, no closing allowed
    write_cfg(0, 0, 65535);
    queue_rec(mk(1, 0, 0, 4000, 0, 10, 0));
    queue_rec(mk(1, 1, 0, 4000, 32768, 10, 1));
    wait_drained();

    write_cfg(0, 65535, 65535);
    queue_rec(mk(1, 0, 0, 65535, 0, 10, 0));
    queue_rec(mk(1, 100, 0, 65535, 32768, 10, 1));
    wait_drained();

    // Random sets at defaults, first with no idling, then with idling
    write_cfg(384, 2240, 16);
    idle_on = 1'b0;
    add_random(60);
    wait_drained();
    idle_on = 1'b1;
    add_random(40);
    wait_drained();

    // Table overflow: more present records than slots
    write_cfg($urandom_range(0, 262143), 2240, $urandom_range(0, 64));
    for (int k = 0; k < 68; k++)
      queue_rec(mk(1, $urandom_range(0, 6000), $urandom_range(0, 6000),
                   $urandom_range(0, 3000), $urandom_range(0, 65535),
                   $urandom_range(0, 200), k == 67));
    wait_drained();

    write_cfg($urandom_range(0, 262143), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    add_random(50);
    wait_drained();

    write_cfg(262143, 65535, 0);
    add_random(50);
    wait_drained();

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
